FILE: rtl/sxd_pkg.sv
// ----------------------------------------------------------------------------
// sxd_pkg
// Types, byte codes and constant tables shared by the sixel stream decoder.
// ----------------------------------------------------------------------------
package sxd_pkg;

   // input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   // result item: one plotted run
   typedef struct packed {
      logic [12:0] column_start;
      logic [13:0] run_length;
      logic [10:0] band_row;
      logic [5:0]  pixel_mask;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } rsp_type;

   // colour conversion request
   typedef struct packed {
      logic [15:0] system;
      logic [15:0] comp_a;
      logic [15:0] comp_b;
      logic [15:0] comp_c;
   } color_cmd_type;

   // colour conversion status
   typedef struct packed {
      logic        busy;
      logic [23:0] rgb;
   } color_sts_type;

   // byte codes
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] SIXEL_LO  = 8'h3F;
   localparam logic [7:0] SIXEL_HI  = 8'h7E;

   // parse modes
   localparam logic [2:0] M_TOP    = 3'd0;
   localparam logic [2:0] M_SEL    = 3'd1;
   localparam logic [2:0] M_SYS    = 3'd2;
   localparam logic [2:0] M_CA     = 3'd3;
   localparam logic [2:0] M_CB     = 3'd4;
   localparam logic [2:0] M_CC     = 3'd5;
   localparam logic [2:0] M_RASTER = 3'd6;
   localparam logic [2:0] M_REP    = 3'd7;

   localparam logic [23:0] WHITE   = 24'hFFFFFF;
   localparam logic [15:0] NUM_SAT = 16'hFFFF;
   localparam logic [15:0] SYS_HLS = 16'd1;

   // percent to 8-bit channel, v*255/100
   typedef logic [7:0] pct_tab_type [0:100];
   // percent to Q1.16, v*65536/100
   typedef logic [16:0] q16_tab_type [0:100];

   function automatic pct_tab_type make_pct_tab();
      pct_tab_type t;
      for (int i = 0; i <= 100; i++) t[i] = 8'(i * 255 / 100);
      return t;
   endfunction

   function automatic q16_tab_type make_q16_tab();
      q16_tab_type t;
      for (int i = 0; i <= 100; i++) t[i] = 17'(i * 65536 / 100);
      return t;
   endfunction

   localparam pct_tab_type PCT_TAB = make_pct_tab();
   localparam q16_tab_type Q16_TAB = make_q16_tab();

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_sixel(input logic [7:0] c);
      return (c >= SIXEL_LO) && (c <= SIXEL_HI);
   endfunction

   // clamp a percent value to 0..100
   function automatic logic [6:0] clamp_pct(input logic [15:0] v);
      return (v > 16'd100) ? 7'd100 : v[6:0];
   endfunction

endpackage

FILE: rtl/sxd_ram.sv
// ----------------------------------------------------------------------------
// sxd_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sxd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sxd_color.sv
// ----------------------------------------------------------------------------
// sxd_color
// Colour define conversion: percent RGB and zero saturation HLS straight from idle,
// other HLS through a sequence of registered steps sharing one datapath.
// ----------------------------------------------------------------------------
module sxd_color (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  sxd_pkg::color_cmd_type cmd,
   output sxd_pkg::color_sts_type sts
);
   import sxd_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_HMOD  = 4'd1;
   localparam logic [3:0] S_HSUB  = 4'd2;
   localparam logic [3:0] S_HQ    = 4'd3;
   localparam logic [3:0] S_PROD  = 4'd4;
   localparam logic [3:0] S_M12   = 4'd5;
   localparam logic [3:0] S_HUE   = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_VAL   = 4'd8;
   localparam logic [3:0] S_CHAN  = 4'd9;

   localparam logic [16:0] RECIP_360 = 17'd93207;     // 2^25/360 rounded up
   localparam logic [23:0] HUE_SCALE = 24'd11930465;  // 2^32/360 rounded up

   logic [3:0]         step_ff, step_in;
   logic [15:0]        h_ff, h_in;
   logic [6:0]         l_ff, l_in, s_ff, s_in;
   logic [7:0]         q_ff, q_in;
   logic [8:0]         hm_ff, hm_in;
   logic [15:0]        hq_ff, hq_in;
   logic [16:0]        p_ff, p_in;
   logic signed [18:0] m1_ff, m1_in, m2_ff, m2_in, d_ff, d_in;
   logic [1:0]         ch_ff, ch_in;
   logic [16:0]        t_ff, t_in;
   logic [1:0]         br_ff, br_in;
   logic signed [20:0] sh_ff, sh_in;
   logic [16:0]        v_ff, v_in;
   logic [23:0]        rgb_ff, rgb_in;

   logic [32:0]        prod_q, prod_h;
   logic [33:0]        prod_p;
   logic [16:0]        lq, sq;
   logic signed [18:0] x;
   logic [16:0]        xu;
   logic [19:0]        six_x, tri_x, rev_x;
   logic signed [36:0] prod_d;
   logic signed [21:0] vs;
   logic [24:0]        prod_c;
   logic [7:0]         chan;
   logic [6:0]         cl_a, cl_b, cl_c;

   assign lq = Q16_TAB[l_ff];
   assign sq = Q16_TAB[s_ff];

   // step sequencer and datapath
   always_comb begin
      step_in = step_ff;
      h_in = h_ff; l_in = l_ff; s_in = s_ff;
      q_in = q_ff; hm_in = hm_ff; hq_in = hq_ff; p_in = p_ff;
      m1_in = m1_ff; m2_in = m2_ff; d_in = d_ff;
      ch_in = ch_ff; t_in = t_ff; br_in = br_ff; sh_in = sh_ff; v_in = v_ff;
      rgb_in = rgb_ff;
      cl_a = clamp_pct(cmd.comp_a);
      cl_b = clamp_pct(cmd.comp_b);
      cl_c = clamp_pct(cmd.comp_c);
      prod_q = 33'(h_ff) * 33'(RECIP_360);
      prod_h = 33'(hm_ff) * 33'(HUE_SCALE);
      prod_p = 34'(lq) * 34'(sq);
      x = 19'(hq_ff);
      xu = '0;
      six_x = '0; tri_x = '0; rev_x = '0;
      prod_d = d_ff * $signed({1'b0, t_ff});
      vs = '0;
      prod_c = 25'(v_ff) * 25'd255;
      chan = (prod_c[24:16] > 9'd255) ? 8'd255 : prod_c[23:16];
      case (step_ff)
         S_IDLE: begin
            if (start) begin
               if (cmd.system != SYS_HLS) begin
                  rgb_in = {(cmd.comp_a > 16'd100) ? 8'd255 : PCT_TAB[cl_a],
                            (cmd.comp_b > 16'd100) ? 8'd255 : PCT_TAB[cl_b],
                            (cmd.comp_c > 16'd100) ? 8'd255 : PCT_TAB[cl_c]};
               end else if (cl_c == 7'd0) begin
                  rgb_in = {3{PCT_TAB[cl_b]}};
               end else begin
                  h_in = cmd.comp_a;
                  l_in = cl_b;
                  s_in = cl_c;
                  step_in = S_HMOD;
               end
            end
         end
         // quotient of hue by 360
         S_HMOD: begin
            q_in = prod_q[32:25];
            step_in = S_HSUB;
         end
         S_HSUB: begin
            hm_in = 9'(h_ff - 16'(q_ff) * 16'd360);
            step_in = S_HQ;
         end
         S_HQ: begin
            hq_in = prod_h[31:16];
            step_in = S_PROD;
         end
         S_PROD: begin
            p_in = prod_p[32:16];
            step_in = S_M12;
         end
         S_M12: begin
            if (lq <= 17'd32768) m2_in = 19'(lq) + 19'(p_ff);
            else m2_in = 19'(lq) + 19'(sq) - 19'(p_ff);
            m1_in = 19'({lq, 1'b0}) - m2_in;
            d_in = m2_in - m1_in;
            ch_in = 2'd0;
            step_in = S_HUE;
         end
         // hue offset, wrap and segment choice
         S_HUE: begin
            case (ch_ff)
               2'd0:    x = 19'(hq_ff) + 19'sd21845;
               2'd1:    x = 19'(hq_ff);
               default: x = 19'(hq_ff) - 19'sd21845;
            endcase
            if (x < 0) x = x + 19'sd65536;
            if (x > 19'sd65536) x = x - 19'sd65536;
            xu = x[16:0];
            six_x = 20'(xu) * 20'd6;
            tri_x = 20'(xu) * 20'd3;
            rev_x = (20'd43690 - 20'(xu)) * 20'd6;
            if (six_x < 20'd65536) begin
               t_in = six_x[16:0];
               br_in = 2'd0;
            end else if (xu < 17'd32768) begin
               br_in = 2'd1;
            end else if (tri_x < 20'd131072) begin
               t_in = rev_x[16:0];
               br_in = 2'd0;
            end else begin
               br_in = 2'd2;
            end
            step_in = S_MUL;
         end
         S_MUL: begin
            sh_in = prod_d[36:16];
            step_in = S_VAL;
         end
         S_VAL: begin
            case (br_ff)
               2'd0:    vs = 22'(m1_ff) + 22'(sh_ff);
               2'd1:    vs = 22'(m2_ff);
               default: vs = 22'(m1_ff);
            endcase
            v_in = (vs < 0) ? 17'd0 : vs[16:0];
            step_in = S_CHAN;
         end
         S_CHAN: begin
            case (ch_ff)
               2'd0:    rgb_in[23:16] = chan;
               2'd1:    rgb_in[15:8] = chan;
               default: rgb_in[7:0] = chan;
            endcase
            if (ch_ff == 2'd2) begin
               step_in = S_IDLE;
            end else begin
               ch_in = ch_ff + 2'd1;
               step_in = S_HUE;
            end
         end
         default: step_in = S_IDLE;
      endcase
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) step_ff <= S_IDLE;
      else step_ff <= step_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      h_ff <= h_in; l_ff <= l_in; s_ff <= s_in;
      q_ff <= q_in; hm_ff <= hm_in; hq_ff <= hq_in; p_ff <= p_in;
      m1_ff <= m1_in; m2_ff <= m2_in; d_ff <= d_in;
      ch_ff <= ch_in; t_ff <= t_in; br_ff <= br_in; sh_ff <= sh_in;
      v_ff <= v_in; rgb_ff <= rgb_in;
   end

   assign sts.busy = (step_ff != S_IDLE);
   assign sts.rgb  = rgb_ff;

endmodule

FILE: rtl/sixel_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// sixel_stream_decoder_top
// Sixel payload parser: cursor, colour and palette tracking, one run per
// plotted sixel. The palette lives in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | direction | ports                        | payload
//  req     | in        | req_valid, req_stall         | data_byte, frame_start
//  rsp     | out       | rsp_valid, rsp_stall         | one plotted run
//
//  most bytes take only the idle state; a colour select adds a select state
//  (palette RAM read), a colour define a colour state that waits out the 17
//  steps of the colour unit for an HLS define with nonzero saturation. reset
//  is synchronous and clears parser, cursor and palette valid bits at once. a
//  result waits in the output register; a new byte is taken while it drains.
// ----------------------------------------------------------------------------
module sixel_stream_decoder_top #(
   parameter int MAX_WIDTH    = 8192,
   parameter int MAX_BANDS    = 1365,
   parameter int PALETTE_SIZE = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sxd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sxd_pkg::rsp_type rsp_data
);
   import sxd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int BW = $clog2(MAX_BANDS + 1);
   localparam int PW = $clog2(PALETTE_SIZE);
   localparam int SW = ((CW > 16) ? CW : 16) + 1;
   localparam logic [PW-1:0] SAT_MOD = PW'(65535 % PALETTE_SIZE);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SELECT = 2'd1;
   localparam logic [1:0] ST_COLOR  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [2:0]        mode_ff, mode_in, mode_e;
   logic [15:0]       accum_ff, accum_in, accum_e;
   logic [PW-1:0]     selmod_ff, selmod_in, selmod_e;
   logic [PW-1:0]     regidx_ff, regidx_in, regidx_e;
   logic [15:0]       sys_ff, sys_in, sys_e;
   logic [15:0]       ca_ff, ca_in, ca_e, cb_ff, cb_in, cb_e, cc_ff, cc_in, cc_e;
   logic [15:0]       rep_ff, rep_in, rep_e;
   logic [CW-1:0]     col_ff, col_in, col_e;
   logic [BW-1:0]     band_ff, band_in, band_e;
   logic [23:0]       color_ff, color_in, color_e;
   logic [7:0]        byte_ff, byte_in;
   logic [PALETTE_SIZE-1:0] valid_ff, valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept, fs_hit, out_free;
   logic              do_top, do_paint, color_start;
   logic [7:0]        tb;
   logic [15:0]       rep_n;
   logic [19:0]       acc_sum;
   logic [19:0]       rep_sum;
   logic [15:0]       acc_val;
   logic              acc_sat;
   logic [PW+3:0]     mod_sum, mod_red;
   logic [5:0]        bits;
   logic [SW-1:0]     col_sum, room, len;
   logic              pal_wr;
   logic [PW-1:0]     pal_rd_addr;
   logic [23:0]       pal_rd_data;
   color_cmd_type     ccmd;
   color_sts_type     csts;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign fs_hit    = accept && req_data.frame_start;

   // state as seen by this byte, frame start applied
   always_comb begin
      mode_e   = fs_hit ? M_TOP : mode_ff;
      accum_e  = fs_hit ? '0 : accum_ff;
      selmod_e = fs_hit ? '0 : selmod_ff;
      regidx_e = fs_hit ? '0 : regidx_ff;
      sys_e    = fs_hit ? '0 : sys_ff;
      ca_e     = fs_hit ? '0 : ca_ff;
      cb_e     = fs_hit ? '0 : cb_ff;
      cc_e     = fs_hit ? '0 : cc_ff;
      rep_e    = fs_hit ? '0 : rep_ff;
      col_e    = fs_hit ? '0 : col_ff;
      band_e   = fs_hit ? '0 : band_ff;
      color_e  = fs_hit ? WHITE : color_ff;
   end

   // decimal digit step, with the palette index kept modulo the size
   always_comb begin
      acc_sum = 20'(accum_e) * 20'd10 + 20'(req_data.data_byte[3:0]);
      acc_sat = (acc_sum > 20'(NUM_SAT));
      acc_val = acc_sat ? NUM_SAT : acc_sum[15:0];
      rep_sum = 20'(rep_e) * 20'd10 + 20'(req_data.data_byte[3:0]);
      mod_sum = (PW+4)'(selmod_e) * (PW+4)'(10) + (PW+4)'(req_data.data_byte[3:0]);
      mod_red = mod_sum;
      for (int k = 1; k <= 9; k++) begin
         if (mod_sum >= (PW+4)'(k * PALETTE_SIZE)) mod_red = mod_sum - (PW+4)'(k * PALETTE_SIZE);
      end
   end

   // parser, cursor and result
   always_comb begin
      state_in = state_ff;
      mode_in = mode_e; accum_in = accum_e; selmod_in = selmod_e; regidx_in = regidx_e;
      sys_in = sys_e; ca_in = ca_e; cb_in = cb_e; cc_in = cc_e; rep_in = rep_e;
      col_in = col_e; band_in = band_e; color_in = color_e;
      byte_in = byte_ff;
      valid_in = valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      do_top = 1'b0; do_paint = 1'b0; color_start = 1'b0; pal_wr = 1'b0;
      tb = req_data.data_byte;
      rep_n = 16'd1;
      ccmd = '{system: sys_e, comp_a: ca_e, comp_b: cb_e, comp_c: cc_e};
      bits = '0; col_sum = '0; room = '0; len = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.frame_start) valid_in = '0;
               byte_in = req_data.data_byte;
               case (mode_e)
                  M_SEL: begin
                     if (is_digit(tb)) begin
                        accum_in = acc_val;
                        selmod_in = acc_sat ? SAT_MOD : mod_red[PW-1:0];
                     end else begin
                        regidx_in = selmod_e;
                        accum_in = '0;
                        if (tb == CH_SEMI) begin
                           sys_in = '0; ca_in = '0; cb_in = '0; cc_in = '0;
                           mode_in = M_SYS;
                        end else begin
                           mode_in = M_TOP;
                           state_in = ST_SELECT;
                        end
                     end
                  end
                  M_SYS, M_CA, M_CB, M_CC: begin
                     if (is_digit(tb)) begin
                        accum_in = acc_val;
                     end else begin
                        case (mode_e)
                           M_SYS:   sys_in = accum_e;
                           M_CA:    ca_in = accum_e;
                           M_CB:    cb_in = accum_e;
                           default: cc_in = accum_e;
                        endcase
                        accum_in = '0;
                        if (tb == CH_SEMI && mode_e != M_CC) begin
                           mode_in = mode_e + 3'd1;
                        end else begin
                           ccmd = '{system: sys_in, comp_a: ca_in, comp_b: cb_in,
                                    comp_c: cc_in};
                           color_start = 1'b1;
                           mode_in = M_TOP;
                           state_in = ST_COLOR;
                        end
                     end
                  end
                  M_RASTER: begin
                     if (!(is_digit(tb) || tb == CH_SEMI)) begin
                        mode_in = M_TOP;
                        do_top = 1'b1;
                     end
                  end
                  M_REP: begin
                     if (is_digit(tb)) begin
                        rep_in = (rep_sum > 20'(NUM_SAT)) ? NUM_SAT : rep_sum[15:0];
                     end else begin
                        mode_in = M_TOP;
                        if (is_sixel(tb)) begin
                           do_paint = 1'b1;
                           rep_n = (rep_e == 16'd0) ? 16'd1 : rep_e;
                        end
                     end
                  end
                  default: begin
                     mode_in = M_TOP;
                     do_top = 1'b1;
                  end
               endcase
            end
         end
         // palette entry arrives from the RAM
         ST_SELECT: begin
            tb = byte_ff;
            if (out_free) begin
               color_in = valid_ff[regidx_ff] ? pal_rd_data : WHITE;
               do_top = 1'b1;
               state_in = ST_IDLE;
            end
         end
         // converted colour goes to the palette and becomes current
         ST_COLOR: begin
            tb = byte_ff;
            if (!csts.busy && out_free) begin
               color_in = csts.rgb;
               pal_wr = 1'b1;
               valid_in[regidx_ff] = 1'b1;
               do_top = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // top level commands
      if (do_top) begin
         case (tb)
            CH_HASH: begin
               mode_in = M_SEL;
               accum_in = '0;
               selmod_in = '0;
            end
            CH_QUOTE: mode_in = M_RASTER;
            CH_BANG: begin
               mode_in = M_REP;
               rep_in = '0;
            end
            CH_DOLLAR: col_in = '0;
            CH_DASH: begin
               col_in = '0;
               if (band_e < BW'(MAX_BANDS)) band_in = band_e + BW'(1);
            end
            default: if (is_sixel(tb)) do_paint = 1'b1;
         endcase
      end

      // plot a run and advance the column
      if (do_paint) begin
         bits = 6'(tb - SIXEL_LO);
         room = SW'(MAX_WIDTH) - SW'(col_e);
         len = (SW'(rep_n) < room) ? SW'(rep_n) : room;
         if (bits != 6'd0 && SW'(col_e) < SW'(MAX_WIDTH) && band_e < BW'(MAX_BANDS)) begin
            rsp_valid_in = 1'b1;
            rsp_in.column_start = 13'(col_e);
            rsp_in.run_length = 14'(len);
            rsp_in.band_row = 11'(band_e);
            rsp_in.pixel_mask = bits;
            rsp_in.red = color_in[23:16];
            rsp_in.green = color_in[15:8];
            rsp_in.blue = color_in[7:0];
         end
         col_sum = SW'(col_e) + SW'(rep_n);
         col_in = (col_sum > SW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(col_sum);
      end
   end

   assign pal_rd_addr = (state_ff == ST_IDLE) ? selmod_e : regidx_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= M_TOP;
         accum_ff <= '0; selmod_ff <= '0; regidx_ff <= '0;
         sys_ff <= '0; ca_ff <= '0; cb_ff <= '0; cc_ff <= '0; rep_ff <= '0;
         col_ff <= '0; band_ff <= '0; color_ff <= WHITE;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         accum_ff <= accum_in; selmod_ff <= selmod_in; regidx_ff <= regidx_in;
         sys_ff <= sys_in; ca_ff <= ca_in; cb_ff <= cb_in; cc_ff <= cc_in;
         rep_ff <= rep_in;
         col_ff <= col_in; band_ff <= band_in; color_ff <= color_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rsp_ff <= rsp_in;
   end

   // palette store
   sxd_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_SIZE)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr),
      .wr_addr (regidx_ff),
      .wr_data (csts.rgb),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_rd_data)
   );

   // colour conversion
   sxd_color u_color (
      .clock (clock),
      .reset (reset),
      .start (color_start),
      .cmd   (ccmd),
      .sts   (csts)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: dv/sixel_stream_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// sixel_stream_decoder_top_tb
// Drives sixel payload bytes into the decoder and checks every plotted run
// against a behavioral predictor of the parser, cursor and palette, with
// random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sixel_stream_decoder_top_tb;
   import sxd_pkg::*;

   localparam int MAX_WIDTH    = 8192;
   localparam int MAX_BANDS    = 1365;
   localparam int PALETTE_SIZE = 256;
   localparam int IDLE_LIMIT   = 2000;
   localparam int N_RANDOM     = 460;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   sixel_stream_decoder_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // predictor state
   logic [2:0]  p_mode;
   logic [15:0] p_num, p_sys, p_ca, p_cb, p_cc, p_rep;
   logic [7:0]  p_reg;
   int          p_col, p_band;
   logic [23:0] p_color;
   logic [23:0] p_pal [PALETTE_SIZE];
   bit          p_pal_ok [PALETTE_SIZE];

   rsp_type run_queue [$];
   int      errors;
   int      send_idle_pct, recv_idle_pct;
   int      idle_cycles;
   int      n_sent;
   bit      exp_run_given;
   rsp_type exp_run;
   rsp_type rcv_run;

   function automatic logic [15:0] add_digit(logic [15:0] v, logic [7:0] c);
      int r;
      r = v * 10 + (c - 8'h30);
      return (r > 65535) ? 16'hFFFF : 16'(r);
   endfunction

   function automatic logic [7:0] sat8(longint v);
      return (v > 255) ? 8'd255 : 8'(v);
   endfunction

   function automatic logic [7:0] hue_to_chan(longint m1, longint m2, longint x);
      longint d, v;
      d = m2 - m1;
      if (x < 0) x += 65536;
      if (x > 65536) x -= 65536;
      if (6 * x < 65536) v = m1 + ((d * 6 * x) >>> 16);
      else if (2 * x < 65536) v = m2;
      else if (3 * x < 131072) v = m1 + ((d * (43690 - x) * 6) >>> 16);
      else v = m1;
      if (v < 0) v = 0;
      return sat8((v * 255) >>> 16);
   endfunction

   function automatic logic [23:0] hls_to_rgb(longint h, longint l, longint s);
      longint lq, sq, hq, pp, m1, m2, g;
      h = h % 360;
      if (l > 100) l = 100;
      if (s > 100) s = 100;
      if (s == 0) begin
         g = l * 255 / 100;
         return {8'(g), 8'(g), 8'(g)};
      end
      lq = l * 65536 / 100;
      sq = s * 65536 / 100;
      hq = h * 65536 / 360;
      pp = (lq * sq) >>> 16;
      m2 = (lq <= 32768) ? lq + pp : lq + sq - pp;
      m1 = 2 * lq - m2;
      return {hue_to_chan(m1, m2, hq + 21845), hue_to_chan(m1, m2, hq),
              hue_to_chan(m1, m2, hq - 21845)};
   endfunction

   task automatic clear_decoder();
      p_mode = M_TOP; p_num = 0; p_reg = 0; p_sys = 0;
      p_ca = 0; p_cb = 0; p_cc = 0; p_rep = 0;
      p_col = 0; p_band = 0; p_color = WHITE;
      for (int i = 0; i < PALETTE_SIZE; i++) begin
         p_pal[i] = '0;
         p_pal_ok[i] = 0;
      end
   endtask

   task automatic plot_run(logic [7:0] c, int count);
      rsp_type r;
      int room;
      if (c != SIXEL_LO && p_col < MAX_WIDTH && p_band < MAX_BANDS) begin
         room = MAX_WIDTH - p_col;
         r.column_start = 13'(p_col);
         r.run_length   = 14'((count < room) ? count : room);
         r.band_row     = 11'(p_band);
         r.pixel_mask   = 6'(c - SIXEL_LO);
         {r.red, r.green, r.blue} = p_color;
         run_queue.push_back(r);
      end
      p_col += count;
      if (p_col > MAX_WIDTH) p_col = MAX_WIDTH;
   endtask

   task automatic top_byte(logic [7:0] c);
      if (c == CH_HASH) begin
         p_mode = M_SEL; p_num = 0;
      end else if (c == CH_QUOTE) begin
         p_mode = M_RASTER;
      end else if (c == CH_BANG) begin
         p_mode = M_REP; p_rep = 0;
      end else if (c == CH_DOLLAR) begin
         p_col = 0;
      end else if (c == CH_DASH) begin
         p_col = 0;
         if (p_band < MAX_BANDS) p_band++;
      end else if (c >= SIXEL_LO && c <= SIXEL_HI) begin
         plot_run(c, 1);
      end
   endtask

   // predict the runs caused by one accepted byte
   task automatic decode_byte(req_type t);
      logic [7:0] c;
      bit digit;
      logic [23:0] rgb;
      c = t.data_byte;
      digit = (c >= 8'h30 && c <= 8'h39);
      if (t.frame_start) clear_decoder();
      case (p_mode)
         M_SEL: begin
            if (digit) p_num = add_digit(p_num, c);
            else begin
               p_reg = p_num[7:0];
               p_num = 0;
               if (c == CH_SEMI) begin
                  p_sys = 0; p_ca = 0; p_cb = 0; p_cc = 0;
                  p_mode = M_SYS;
               end else begin
                  p_color = p_pal_ok[p_reg] ? p_pal[p_reg] : WHITE;
                  p_mode = M_TOP;
                  top_byte(c);
               end
            end
         end
         M_SYS, M_CA, M_CB, M_CC: begin
            if (digit) p_num = add_digit(p_num, c);
            else begin
               case (p_mode)
                  M_SYS:   p_sys = p_num;
                  M_CA:    p_ca = p_num;
                  M_CB:    p_cb = p_num;
                  default: p_cc = p_num;
               endcase
               p_num = 0;
               if (c == CH_SEMI && p_mode != M_CC) p_mode = p_mode + 3'd1;
               else begin
                  if (p_sys == SYS_HLS) rgb = hls_to_rgb(p_ca, p_cb, p_cc);
                  else rgb = {sat8(longint'(p_ca) * 255 / 100),
                              sat8(longint'(p_cb) * 255 / 100),
                              sat8(longint'(p_cc) * 255 / 100)};
                  p_color = rgb;
                  p_pal[p_reg] = rgb;
                  p_pal_ok[p_reg] = 1;
                  p_mode = M_TOP;
                  top_byte(c);
               end
            end
         end
         M_RASTER: begin
            if (!(digit || c == CH_SEMI)) begin
               p_mode = M_TOP;
               top_byte(c);
            end
         end
         M_REP: begin
            if (digit) p_rep = add_digit(p_rep, c);
            else begin
               p_mode = M_TOP;
               if (c >= SIXEL_LO && c <= SIXEL_HI)
                  plot_run(c, (p_rep == 0) ? 1 : int'(p_rep));
            end
         end
         default: begin
            p_mode = M_TOP;
            top_byte(c);
         end
      endcase
   endtask

   // clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // receiver: random stall, compare each transfer with the oldest prediction
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (run_queue.size() == 0) begin
            $error("unexpected run transfer %p", rsp_data);
            errors++;
         end else begin
            rcv_run = run_queue.pop_front();
            if (rsp_data.column_start !== rcv_run.column_start) begin
               $error("column_start exp %0d got %0d", rcv_run.column_start,
                      rsp_data.column_start); errors++; end
            if (rsp_data.run_length !== rcv_run.run_length) begin
               $error("run_length exp %0d got %0d", rcv_run.run_length,
                      rsp_data.run_length); errors++; end
            if (rsp_data.band_row !== rcv_run.band_row) begin
               $error("band_row exp %0d got %0d", rcv_run.band_row,
                      rsp_data.band_row); errors++; end
            if (rsp_data.pixel_mask !== rcv_run.pixel_mask) begin
               $error("pixel_mask exp %h got %h", rcv_run.pixel_mask,
                      rsp_data.pixel_mask); errors++; end
            if (rsp_data.red !== rcv_run.red) begin
               $error("red exp %h got %h", rcv_run.red, rsp_data.red); errors++; end
            if (rsp_data.green !== rcv_run.green) begin
               $error("green exp %h got %h", rcv_run.green, rsp_data.green); errors++; end
            if (rsp_data.blue !== rcv_run.blue) begin
               $error("blue exp %h got %h", rcv_run.blue, rsp_data.blue); errors++; end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // send one byte; directed rows may carry a typed-in expected run
   task automatic send_byte(logic [7:0] b, bit fs);
      req_type t;
      t.data_byte = b;
      t.frame_start = fs;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_sent++;
      decode_byte(t);
      if (exp_run_given) begin
         if (run_queue.size() == 0 || run_queue[$] !== exp_run) begin
            $error("directed row: predictor disagrees with typed-in run");
            errors++;
         end
         exp_run_given = 0;
      end
   endtask

   task automatic send_text(string s, bit fs);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], fs && i == 0);
   endtask

   task automatic send_number(int v);
      send_text($sformatf("%0d", v), 0);
   endtask

   // random chunk of one or more bytes, biased toward well-formed commands
   task automatic send_random_chunk();
      int k;
      k = $urandom_range(99);
      if (k < 35) send_byte(8'($urandom_range(SIXEL_LO, SIXEL_HI)),
                            $urandom_range(99) == 0);
      else if (k < 47) begin
         send_byte(CH_HASH, 0);
         send_number($urandom_range(15));
         if ($urandom_range(1)) begin
            send_byte(CH_SEMI, 0);
            send_number($urandom_range(3) == 0 ? 1 : 2);
            send_byte(CH_SEMI, 0); send_number($urandom_range(400));
            send_byte(CH_SEMI, 0); send_number($urandom_range(120));
            send_byte(CH_SEMI, 0); send_number($urandom_range(120));
         end
      end else if (k < 57) begin
         send_byte(CH_BANG, 0);
         send_number($urandom_range(3) == 0 ? $urandom_range(9000) : $urandom_range(40));
      end else if (k < 63) send_byte(CH_DOLLAR, 0);
      else if (k < 68) send_byte(CH_DASH, 0);
      else if (k < 72) begin
         send_byte(CH_QUOTE, 0);
         send_text("1;1;20;30", 0);
      end else if (k < 80) send_byte(8'($urandom_range(8'h30, 8'h3B)), 0);
      else send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
   endtask

   // directed stimulus table: byte, frame start, typed-in run given
   typedef struct {
      logic [7:0] b;
      bit         fs;
      bit         given;
      rsp_type    run;
   } row_type;

   row_type dir_rows [$];

   task automatic add_row(logic [7:0] b, bit fs, bit given = 0, rsp_type r = '0);
      row_type w;
      w.b = b; w.fs = fs; w.given = given; w.run = r;
      dir_rows.push_back(w);
   endtask

   initial begin
      rsp_type r;
      int stop_at;
      errors = 0;
      idle_cycles = 0;
      n_sent = 0;
      exp_run_given = 0;
      send_idle_pct = 29;
      recv_idle_pct = 50;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      clear_decoder();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // after reset: full mask in white at the origin
      r = '{column_start: 0, run_length: 1, band_row: 0, pixel_mask: 6'h3F,
            red: 8'hFF, green: 8'hFF, blue: 8'hFF};
      add_row(SIXEL_HI, 1, 1, r);
      add_row(SIXEL_LO, 0);            // empty sixel advances only
      add_row(8'h40, 0);
      // saturating repeat clipped at the right edge
      add_row(CH_BANG, 0);
      repeat (5) add_row(8'h39, 0);
      r = '{column_start: 3, run_length: 14'(MAX_WIDTH - 3), band_row: 0,
            pixel_mask: 6'h01, red: 8'hFF, green: 8'hFF, blue: 8'hFF};
      add_row(8'h40, 0, 1, r);
      add_row(8'h41, 0);               // beyond width: no run
      add_row(CH_DOLLAR, 0);
      add_row(CH_DASH, 0);
      add_row(CH_QUOTE, 0); add_row(8'h31, 0); add_row(CH_SEMI, 0);
      add_row(8'h7D, 0);
      add_row(CH_HASH, 0); add_row(8'h35, 0); add_row(8'h48, 0); // undefined select
      add_row(CH_BANG, 0); add_row(8'h30, 0); add_row(8'h20, 0); // repeat dropped
      add_row(8'hFF, 0); add_row(8'h00, 0);
      foreach (dir_rows[i]) begin
         exp_run_given = dir_rows[i].given;
         exp_run = dir_rows[i].run;
         send_byte(dir_rows[i].b, dir_rows[i].fs);
      end
      // colour defines: RGB over 100 percent, HLS grey, HLS hue, index wrap
      send_text("#300;2;100;0;65535~", 0);
      send_text("#1;1;0;50;0~#2;1;120;50;100;7~#3;1;65535;100;100~", 0);
      send_text("#44;9~#300~", 0);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 50 : 0;
         recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 29 : 0;
         send_byte(8'h3F, 1);
         stop_at = n_sent + N_RANDOM / 3;
         while (n_sent < stop_at) send_random_chunk();
      end
      req_valid <= 1'b0;

      while (run_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
